[design/srrf_pkg.sv]
`default_nettype none

package srrf_pkg;

  // state code: bit 2 is agent mode, bits 1:0 are idle or the kind waited for
  typedef enum logic [2:0] {
    ST_MC_IDLE = 3'd0,
    ST_MC_SRV  = 3'd1,
    ST_MC_TYPE = 3'd2,
    ST_MC_ATTR = 3'd3,
    ST_AG_IDLE = 3'd4,
    ST_AG_SRV  = 3'd5,
    ST_AG_TYPE = 3'd6,
    ST_AG_ATTR = 3'd7
  } fsm_state_t;

  // event codes, codes above timeout are ignored
  typedef enum logic [3:0] {
    CMD_SRV_REQ    = 4'd0,
    CMD_TYPE_REQ   = 4'd1,
    CMD_ATTR_REQ   = 4'd2,
    CMD_CLOSE      = 4'd3,
    CMD_ADVERT     = 4'd4,
    CMD_SRV_REPLY  = 4'd5,
    CMD_TYPE_REPLY = 4'd6,
    CMD_ATTR_REPLY = 4'd7,
    CMD_TIMEOUT    = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SEND    = 2'd1,
    ACT_RETX    = 2'd2,
    ACT_DELIVER = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    TMR_LEAVE   = 2'd0,
    TMR_RESTART = 2'd1,
    TMR_STOP    = 2'd2
  } timer_cmd_t;

  localparam logic [1:0] KIND_SRV  = 2'd0;
  localparam logic [1:0] KIND_ATTR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_MULTICAST_LIMIT = 2'd1;
  localparam logic [1:0] REG_AGENT_LIMIT     = 2'd2;
  localparam logic [1:0] REG_AGENT_KNOWN     = 2'd3;

  localparam int          ELAPSED_W   = 20;
  localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

  localparam logic [15:0] RETRY_INTERVAL_RST  = 16'd2000;
  localparam logic [19:0] MULTICAST_LIMIT_RST = 20'd15000;
  localparam logic [19:0] AGENT_LIMIT_RST     = 20'd15000;

  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] new_xid;
    logic [7:0]  peer_handle;
    logic [15:0] reply_error;
  } evt_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  request_kind;
    logic        to_multicast;
    logic [7:0]  dest_handle;
    logic [15:0] xid_out;
    logic [15:0] indicated_error;
    logic [1:0]  timer_cmd;
    logic [2:0]  fsm_state;
  } res_word_t;

endpackage

`default_nettype wire

[design/srrf_chan_if.sv]
`default_nettype none

interface srrf_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/service_request_retry_fsm.sv]
`default_nettype none

// channel  role    word         handshake
// evt      sink    evt_word_t   valid/ready, accepted when both high
// res      source  res_word_t   valid/ready, accepted when both high
// cfg      write   cfg_data     cfg_we, cfg_index selects the register
//
// one event per cycle while the skid word is empty: state update and result are formed in the
// accept cycle from the state registers, a single compare and saturating add per mode.
// the result word is registered; a two-word output buffer (result register plus
// skid) keeps evt ready while one finished word waits on res.
// evt.ready drops only while both output words are held.
// rst is synchronous and clears state and registers and empties both output words.

module service_request_retry_fsm (
  input  wire logic        clk,
  input  wire logic        rst,
  srrf_chan_if.sink        evt,
  srrf_chan_if.source      res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  import srrf_pkg::*;

  // configuration registers
  logic [15:0] retry_interval;
  logic [19:0] multicast_limit;
  logic [19:0] agent_limit;
  logic        agent_known;

  // block state
  fsm_state_t      state, state_next;
  logic [19:0]     mc_elapsed, mc_elapsed_next;
  logic [19:0]     uc_elapsed, uc_elapsed_next;
  logic [15:0]     xid, xid_next;
  logic [7:0]      dest, dest_next;
  logic            pend_mc, pend_mc_next;

  // output buffer
  res_word_t out_q, skid_q, res_word;
  logic      out_valid, skid_valid;

  logic accept, pop;
  assign evt.ready = !skid_valid;
  assign accept    = evt.valid && evt.ready;
  assign pop       = out_valid && res.ready;
  assign res.valid   = out_valid;
  assign res.payload = out_q;

  // event decode
  evt_word_t   ew;
  logic [3:0]  cmd;
  logic        agent;
  logic [1:0]  sub;
  logic [1:0]  wkind;
  logic [3:0]  reply_off;
  logic        is_close, is_req, is_adv, is_match, is_tmo, el_ok;
  logic [19:0] el_sel, lim_sel;
  logic [20:0] mc_sum, uc_sum;
  logic [19:0] mc_sat, uc_sat;

  assign ew        = evt.payload;
  assign cmd       = ew.command;
  assign agent     = state[2];
  assign sub       = state[1:0];
  assign wkind     = sub - 2'd1;
  assign reply_off = cmd - CMD_SRV_REPLY;
  assign is_close  = (cmd == CMD_CLOSE);
  assign is_req    = (cmd <= CMD_ATTR_REQ);
  assign is_adv    = (cmd == CMD_ADVERT) && !agent;
  assign is_match  = (cmd >= CMD_SRV_REPLY) && (cmd <= CMD_ATTR_REPLY)
                     && (reply_off == {2'b00, wkind});
  assign is_tmo    = (cmd == CMD_TIMEOUT);
  assign el_sel    = agent ? uc_elapsed : mc_elapsed;
  assign lim_sel   = agent ? agent_limit : multicast_limit;
  assign el_ok     = (el_sel <= lim_sel);

  // saturating accumulators
  assign mc_sum = {1'b0, mc_elapsed} + {5'd0, retry_interval};
  assign uc_sum = {1'b0, uc_elapsed} + {5'd0, retry_interval};
  assign mc_sat = mc_sum[ELAPSED_W] ? ELAPSED_MAX : mc_sum[19:0];
  assign uc_sat = uc_sum[ELAPSED_W] ? ELAPSED_MAX : uc_sum[19:0];

  // next state
  always_comb begin
    state_next = state;
    if (is_close) begin
      state_next = agent_known ? ST_AG_IDLE : ST_MC_IDLE;
    end else if (sub == 2'd0) begin
      if (is_req) begin
        state_next = fsm_state_t'({agent, cmd[1:0] + 2'd1});
      end else if (is_adv) begin
        state_next = ST_AG_IDLE;
      end
    end else begin
      if (is_adv) begin
        state_next = fsm_state_t'({1'b1, sub});
      end else if (is_match) begin
        if (agent) begin
          state_next = ST_AG_IDLE;
        end
      end else if (is_tmo && !el_ok) begin
        state_next = fsm_state_t'({agent, 2'b00});
      end
    end
  end

  // outputs and datapath
  always_comb begin
    logic [1:0] action;
    logic [1:0] kind;
    logic [1:0] timer;
    logic [15:0] ind_err;
    logic        acted;
    action          = ACT_NONE;
    kind            = KIND_SRV;
    timer           = TMR_LEAVE;
    ind_err         = 16'd0;
    acted           = 1'b0;
    mc_elapsed_next = mc_elapsed;
    uc_elapsed_next = uc_elapsed;
    xid_next        = xid;
    dest_next       = dest;
    pend_mc_next    = pend_mc;
    if (is_close) begin
      timer           = TMR_STOP;
      mc_elapsed_next = 20'd0;
      uc_elapsed_next = 20'd0;
      xid_next        = 16'd0;
      dest_next       = 8'd0;
      pend_mc_next    = 1'b0;
    end else if (sub == 2'd0) begin
      if (is_req) begin
        xid_next = ew.new_xid;
        kind     = cmd[1:0];
        action   = ACT_SEND;
        timer    = TMR_RESTART;
        acted    = 1'b1;
        if (agent) begin
          pend_mc_next    = 1'b0;
          dest_next       = ew.peer_handle;
          uc_elapsed_next = uc_sat;
        end else begin
          pend_mc_next    = 1'b1;
          dest_next       = 8'd0;
          mc_elapsed_next = mc_sat;
        end
      end
    end else begin
      if (is_adv) begin
        mc_elapsed_next = 20'd0;
        uc_elapsed_next = 20'd0;
        dest_next       = ew.peer_handle;
        pend_mc_next    = 1'b0;
      end else if (is_match) begin
        action  = ACT_DELIVER;
        kind    = wkind;
        acted   = 1'b1;
        ind_err = (wkind == KIND_ATTR) ? ew.reply_error : 16'd0;
        if (agent) begin
          timer           = TMR_STOP;
          xid_next        = 16'd0;
          dest_next       = 8'd0;
          pend_mc_next    = 1'b0;
          uc_elapsed_next = 20'd0;
        end
      end else if (is_tmo) begin
        if (el_ok) begin
          action = ACT_RETX;
          kind   = wkind;
          acted  = 1'b1;
          timer  = TMR_RESTART;
          if (agent) begin
            uc_elapsed_next = uc_sat;
          end else begin
            mc_elapsed_next = mc_sat;
          end
        end else begin
          timer        = TMR_STOP;
          xid_next     = 16'd0;
          dest_next    = 8'd0;
          pend_mc_next = 1'b0;
          if (agent) begin
            uc_elapsed_next = 20'd0;
          end else begin
            mc_elapsed_next = 20'd0;
          end
        end
      end
    end
    // with no action report the kind waited for after the event
    if (!acted) begin
      kind = (state_next[1:0] != 2'd0) ? state_next[1:0] - 2'd1 : KIND_SRV;
    end
    res_word.action          = action;
    res_word.request_kind    = kind;
    res_word.to_multicast    = pend_mc_next;
    res_word.dest_handle     = dest_next;
    res_word.xid_out         = xid_next;
    res_word.indicated_error = ind_err;
    res_word.timer_cmd       = timer;
    res_word.fsm_state       = state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval  <= RETRY_INTERVAL_RST;
      multicast_limit <= MULTICAST_LIMIT_RST;
      agent_limit     <= AGENT_LIMIT_RST;
      agent_known     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RETRY_INTERVAL:  retry_interval  <= cfg_data[15:0];
        REG_MULTICAST_LIMIT: multicast_limit <= cfg_data;
        REG_AGENT_LIMIT:     agent_limit     <= cfg_data;
        REG_AGENT_KNOWN:     agent_known     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_MC_IDLE;
      mc_elapsed <= 20'd0;
      uc_elapsed <= 20'd0;
      xid        <= 16'd0;
      dest       <= 8'd0;
      pend_mc    <= 1'b0;
    end else if (accept) begin
      state      <= state_next;
      mc_elapsed <= mc_elapsed_next;
      uc_elapsed <= uc_elapsed_next;
      xid        <= xid_next;
      dest       <= dest_next;
      pend_mc    <= pend_mc_next;
    end
  end

  // result register and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || pop) begin
        out_q <= res_word;
      end else begin
        skid_q <= res_word;
      end
    end else if (pop && skid_valid) begin
      out_q <= skid_q;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty result register");

  a_idle_no_xid: assert property (@(posedge clk) disable iff (rst)
    (state[1:0] == 2'd0) |-> (xid == 16'd0))
    else $error("transaction id kept in an idle state");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && evt.payload.command == CMD_CLOSE) |=>
      (xid == 16'd0 && mc_elapsed == 20'd0 && uc_elapsed == 20'd0 && !pend_mc))
    else $error("close left exchange state behind");

  a_send_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && res_word.action == ACT_SEND) |-> (res_word.timer_cmd == TMR_RESTART))
    else $error("send without timer restart");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import srrf_pkg::*;

  // event codes the block must ignore
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_RETRY_INTERVAL;
  logic [19:0] cfg_data = '0;

  srrf_chan_if #(.payload_t(evt_word_t)) evt_ch ();
  srrf_chan_if #(.payload_t(res_word_t)) res_ch ();

  service_request_retry_fsm u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    evt_ch.valid   = 1'b0;
    evt_ch.payload = '0;
    res_ch.ready   = 1'b0;
  end

  // shadow copy of the session state and registers
  logic [2:0]  sess_state;
  logic [19:0] mc_elapsed;
  logic [19:0] uc_elapsed;
  logic [15:0] sess_xid;
  logic [7:0]  sess_dest;
  logic        sess_mc;
  logic [15:0] retry_iv;
  logic [19:0] mc_limit;
  logic [19:0] ag_limit;
  logic        ag_known;

  res_word_t awaited_res[$];
  int        err_count = 0;
  int        n_events = 0;
  int        n_results = 0;
  int        n_cfg = 0;
  int        n_retx = 0;
  int        n_deliver = 0;
  bit        idling = 1'b1;
  int        stall_left = 0;

  function automatic logic [19:0] sat_add(input logic [19:0] acc);
    logic [20:0] sum;
    sum = {1'b0, acc} + {5'd0, retry_iv};
    return (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[19:0];
  endfunction

  function automatic void clear_session();
    sess_state = ag_known ? ST_AG_IDLE : ST_MC_IDLE;
    mc_elapsed = '0;
    uc_elapsed = '0;
    sess_xid   = '0;
    sess_dest  = '0;
    sess_mc    = 1'b0;
  endfunction

  function automatic void load_reg(input logic [1:0] idx, input logic [19:0] data);
    case (idx)
      REG_RETRY_INTERVAL:  retry_iv = data[15:0];
      REG_MULTICAST_LIMIT: mc_limit = data;
      REG_AGENT_LIMIT:     ag_limit = data;
      REG_AGENT_KNOWN:     ag_known = data[0];
      default: ;
    endcase
  endfunction

  // advance the session by one event and form the result word it gives
  function automatic res_word_t step_session(input evt_word_t e);
    res_word_t   r;
    logic        agent;
    logic [1:0]  sub;
    logic [1:0]  wkind;
    logic        acted;
    logic [19:0] el;
    logic [19:0] lim;
    r     = '0;
    acted = 1'b0;
    agent = sess_state[2];
    sub   = sess_state[1:0];
    wkind = sub - 2'd1;
    if (e.command == CMD_CLOSE) begin
      clear_session();
      r.timer_cmd = TMR_STOP;
    end else if (sub == 2'd0) begin
      if (e.command <= CMD_ATTR_REQ) begin
        sess_xid       = e.new_xid;
        r.request_kind = e.command[1:0];
        r.action       = ACT_SEND;
        r.timer_cmd    = TMR_RESTART;
        acted          = 1'b1;
        if (agent) begin
          sess_mc    = 1'b0;
          sess_dest  = e.peer_handle;
          uc_elapsed = sat_add(uc_elapsed);
        end else begin
          sess_mc    = 1'b1;
          sess_dest  = '0;
          mc_elapsed = sat_add(mc_elapsed);
        end
        sess_state = {agent, e.command[1:0] + 2'd1};
      end else if (e.command == CMD_ADVERT && !agent) begin
        sess_state = ST_AG_IDLE;
      end
    end else if (e.command == CMD_ADVERT && !agent) begin
      // advert while waiting in multicast moves the wait to the agent
      mc_elapsed = '0;
      uc_elapsed = '0;
      sess_dest  = e.peer_handle;
      sess_mc    = 1'b0;
      sess_state = {1'b1, sub};
    end else if (e.command >= CMD_SRV_REPLY && e.command <= CMD_ATTR_REPLY &&
                 (e.command - CMD_SRV_REPLY) == {2'b00, wkind}) begin
      r.action          = ACT_DELIVER;
      r.request_kind    = wkind;
      r.indicated_error = (wkind == KIND_ATTR) ? e.reply_error : 16'd0;
      acted             = 1'b1;
      if (agent) begin
        r.timer_cmd = TMR_STOP;
        sess_xid    = '0;
        sess_dest   = '0;
        sess_mc     = 1'b0;
        uc_elapsed  = '0;
        sess_state  = ST_AG_IDLE;
      end
    end else if (e.command == CMD_TIMEOUT) begin
      el  = agent ? uc_elapsed : mc_elapsed;
      lim = agent ? ag_limit : mc_limit;
      if (el <= lim) begin
        r.action       = ACT_RETX;
        r.request_kind = wkind;
        r.timer_cmd    = TMR_RESTART;
        acted          = 1'b1;
        if (agent) uc_elapsed = sat_add(uc_elapsed);
        else mc_elapsed = sat_add(mc_elapsed);
      end else begin
        // retry budget spent: drop the exchange
        r.timer_cmd = TMR_STOP;
        if (agent) uc_elapsed = '0;
        else mc_elapsed = '0;
        sess_xid   = '0;
        sess_dest  = '0;
        sess_mc    = 1'b0;
        sess_state = {agent, 2'b00};
      end
    end
    if (!acted) r.request_kind = (sess_state[1:0] != 2'd0) ? sess_state[1:0] - 2'd1 : KIND_SRV;
    r.to_multicast = sess_mc;
    r.dest_handle  = sess_dest;
    r.xid_out      = sess_xid;
    r.fsm_state    = sess_state;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_word(input res_word_t got, input res_word_t want);
    if (got.action !== want.action)
      report_mismatch("action", 32'(got.action), 32'(want.action));
    if (got.request_kind !== want.request_kind)
      report_mismatch("request_kind", 32'(got.request_kind), 32'(want.request_kind));
    if (got.to_multicast !== want.to_multicast)
      report_mismatch("to_multicast", 32'(got.to_multicast), 32'(want.to_multicast));
    if (got.dest_handle !== want.dest_handle)
      report_mismatch("dest_handle", 32'(got.dest_handle), 32'(want.dest_handle));
    if (got.xid_out !== want.xid_out)
      report_mismatch("xid_out", 32'(got.xid_out), 32'(want.xid_out));
    if (got.indicated_error !== want.indicated_error)
      report_mismatch("indicated_error", 32'(got.indicated_error),
                      32'(want.indicated_error));
    if (got.timer_cmd !== want.timer_cmd)
      report_mismatch("timer_cmd", 32'(got.timer_cmd), 32'(want.timer_cmd));
    if (got.fsm_state !== want.fsm_state)
      report_mismatch("fsm_state", 32'(got.fsm_state), 32'(want.fsm_state));
  endtask

  // result checking, prediction on accepted words, register tracking
  always @(posedge clk) begin
    if (rst) begin
      retry_iv = RETRY_INTERVAL_RST;
      mc_limit = MULTICAST_LIMIT_RST;
      ag_limit = AGENT_LIMIT_RST;
      ag_known = 1'b0;
      clear_session();
      awaited_res.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        if (awaited_res.size() == 0)
          report_mismatch("unexpected result word", {16'd0, res_ch.payload.xid_out}, 32'd0);
        else check_word(res_ch.payload, awaited_res.pop_front());
      end
      if (evt_ch.valid && evt_ch.ready) begin
        awaited_res.insert(awaited_res.size(), step_session(evt_ch.payload));
        n_events++;
        if (awaited_res[$].action == ACT_RETX) n_retx++;
        if (awaited_res[$].action == ACT_DELIVER) n_deliver++;
      end
      if (cfg_we) begin
        load_reg(cfg_index, cfg_data);
        n_cfg++;
      end
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  function automatic evt_word_t evt(input logic [3:0] cmd, input logic [15:0] xid,
                                    input logic [7:0] peer, input logic [15:0] err);
    evt_word_t w;
    w.command     = cmd;
    w.new_xid     = xid;
    w.peer_handle = peer;
    w.reply_error = err;
    return w;
  endfunction

  // present one word, optionally after a gap, and return once it is taken;
  // valid stays high on return so back-to-back words need no toggle
  task automatic send_event(input evt_word_t w);
    if (idling && $urandom_range(0, 3) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    evt_ch.valid   <= 1'b1;
    evt_ch.payload <= w;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    evt_ch.valid <= 1'b0;
    while (awaited_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] iv, input logic [19:0] mcl,
                           input logic [19:0] agl, input logic ak);
    wait_idle();
    // junk above the register width must be dropped
    write_reg(REG_RETRY_INTERVAL, {4'($urandom), iv});
    write_reg(REG_MULTICAST_LIMIT, mcl);
    write_reg(REG_AGENT_LIMIT, agl);
    write_reg(REG_AGENT_KNOWN, {19'($urandom), ak});
  endtask

  function automatic logic [15:0] pick16();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // mostly well-formed exchanges steered by the current session state
  function automatic evt_word_t next_event();
    int         roll;
    logic [1:0] sub;
    logic [3:0] cmd;
    roll = $urandom_range(0, 99);
    sub  = sess_state[1:0];
    if (sub == 2'd0) begin
      if (roll < 70) cmd = 4'($urandom_range(CMD_SRV_REQ, CMD_ATTR_REQ));
      else if (roll < 78) cmd = CMD_ADVERT;
      else if (roll < 84) cmd = CMD_CLOSE;
      else cmd = 4'($urandom_range(0, 15));
    end else begin
      if (roll < 38) cmd = CMD_TIMEOUT;
      else if (roll < 62) cmd = CMD_SRV_REPLY + {2'b00, sub - 2'd1};
      else if (roll < 67) cmd = CMD_ADVERT;
      else if (roll < 70) cmd = CMD_CLOSE;
      else if (roll < 80) cmd = 4'($urandom_range(CMD_SRV_REPLY, CMD_ATTR_REPLY));
      else cmd = 4'($urandom_range(0, 15));
    end
    return evt(cmd, pick16(), 8'($urandom), pick16());
  endfunction

  task automatic run_random(input int count, input bit quiet);
    int i;
    idling = !quiet;
    for (i = 0; i < count; i++) begin
      // alternate stretches with and without idling
      if (!quiet && i % 50 == 0 && i != 0) idling = !idling;
      send_event(next_event());
    end
  endtask

  // a multicast service exchange, one exchange of each kind with the agent, plus the ignored events
  task automatic test_basic_exchange();
    send_event(evt(CMD_CLOSE, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_event(evt(CMD_SRV_REQ, 16'hFFFF, 8'hFF, 16'h0000));
    send_event(evt(CMD_SRV_REPLY, 16'h0000, 8'h00, 16'hFFFF));
    send_event(evt(CMD_TYPE_REPLY, 16'h1234, 8'h12, 16'h0000));
    send_event(evt(CMD_TYPE_REQ, 16'h5555, 8'h55, 16'h0000));
    repeat (3) send_event(evt(CMD_TIMEOUT, 16'hAAAA, 8'hAA, 16'hAAAA));
    send_event(evt(CMD_ADVERT, 16'h0000, 8'hA5, 16'h0000));
    send_event(evt(CMD_TIMEOUT, 16'h0000, 8'h00, 16'h0000));
    send_event(evt(CMD_SRV_REPLY, 16'h0000, 8'h00, 16'h0000));
    send_event(evt(CMD_ADVERT, 16'h0000, 8'h5A, 16'h0000));
    send_event(evt(CMD_TIMEOUT, 16'h0000, 8'h00, 16'h0000));
    send_event(evt(CMD_SRV_REPLY, 16'h0000, 8'h00, 16'h0000));
    send_event(evt(CMD_UNUSED_LO, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_event(evt(CMD_UNUSED_HI, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_event(evt(CMD_ATTR_REQ, 16'h0000, 8'hFF, 16'h0000));
    send_event(evt(CMD_ATTR_REPLY, 16'h0000, 8'h00, 16'hFFFF));
    send_event(evt(CMD_TYPE_REQ, 16'h8001, 8'h00, 16'h0000));
    send_event(evt(CMD_TYPE_REPLY, 16'h0000, 8'h00, 16'hFFFF));
    send_event(evt(CMD_CLOSE, 16'h0000, 8'h00, 16'h0000));
  endtask

  // zero limits drop on the first timeout in both modes
  task automatic test_retry_budget();
    write_all(16'd1, 20'd0, 20'd0, 1'b1);
    send_event(evt(CMD_CLOSE, 16'h0000, 8'h00, 16'h0000));
    send_event(evt(CMD_TYPE_REQ, 16'h7E57, 8'h3C, 16'h0000));
    send_event(evt(CMD_TIMEOUT, 16'h0000, 8'h00, 16'h0000));
    write_all(16'd1, 20'd0, 20'd0, 1'b0);
    send_event(evt(CMD_CLOSE, 16'h0000, 8'h00, 16'h0000));
    send_event(evt(CMD_ATTR_REQ, 16'hC0DE, 8'h11, 16'h0000));
    send_event(evt(CMD_TIMEOUT, 16'h0000, 8'h00, 16'h0000));
  endtask

  // random traffic under several register settings, extremes included
  task automatic test_random_traffic();
    int p;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: write_all(RETRY_INTERVAL_RST, MULTICAST_LIMIT_RST, AGENT_LIMIT_RST, 1'b0);
        1: write_all(16'd1, 20'd0, 20'd0, 1'b1);
        2: write_all(16'hFFFF, ELAPSED_MAX, ELAPSED_MAX, 1'b0);
        3: write_all(16'd300, 20'd5000, 20'd2000, 1'b1);
        4: write_all(16'($urandom_range(1, 65535)), 20'($urandom), 20'($urandom),
                     1'($urandom));
        default: write_all(16'hFFFF, ELAPSED_MAX, 20'd0, 1'b1);
      endcase
      run_random(150, p == 5);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_basic_exchange();
    test_retry_budget();
    test_random_traffic();
    wait_idle();
    repeat (10) @(negedge clk);
    $display("covered %0d events, %0d results, %0d register writes", n_events, n_results,
             n_cfg);
    $display("retransmits %0d, deliveries %0d, mismatches %0d", n_retx, n_deliver, err_count);
    if (err_count == 0 && awaited_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
